### hdl/sem_pkg.sv
`timescale 1ns / 1ps
package sem_pkg;
  localparam int MaxWidthDefault = 1024;
  localparam int HeightLimit = 4096;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] RegFrameWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;
  localparam logic ReqPixel = 1'b0;
  localparam logic ReqDrain = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_last;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input beat, read line buffers
    logic step;     // update window and line buffers, start magnitude
    logic sq_step;  // advance square-root iteration
  } dp_cmd_t;

  typedef struct packed {
    logic sq_done;
  } dp_sts_t;
endpackage

### hdl/sem_if.sv
`timescale 1ns / 1ps
interface sem_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/sem_datapath.sv
`timescale 1ns / 1ps
module sem_datapath #(
  parameter int MaxWidth = sem_pkg::MaxWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sem_pkg::dp_cmd_t  cmd_i,
  output sem_pkg::dp_sts_t  sts_o,
  input  logic [23:0]       pix_i,
  input  logic [$clog2(MaxWidth)-1:0] col_i,
  input  logic              use_pix_i,
  input  logic              row_ge1_i,
  input  logic              row_ge2_i,
  output logic [23:0]       mag_o
);
  localparam int AW = $clog2(MaxWidth);
  logic [23:0] upper_mem [MaxWidth];
  logic [23:0] middle_mem [MaxWidth];
  logic [23:0] up_rd_q, mid_rd_q, pix_q;
  logic [AW-1:0] col_q;
  logic [23:0] win_q [3][3];
  logic [23:0] tmp_q [3][3];
  logic [23:0] m_v, u_v;
  logic        ic0_q;
  logic        ge1_q, ge2_q;

  // row masks are taken with the beat, before the controller advances the row
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      up_rd_q  <= upper_mem[col_i];
      mid_rd_q <= middle_mem[col_i];
      pix_q    <= use_pix_i ? pix_i : 24'd0;
      col_q    <= col_i;
      ic0_q    <= (col_i == '0);
      ge1_q    <= row_ge1_i;
      ge2_q    <= row_ge2_i;
    end
    if (cmd_i.step) begin
      upper_mem[col_q]  <= m_v;
      middle_mem[col_q] <= pix_q;
    end
  end

  assign m_v = ge1_q ? mid_rd_q : 24'd0;
  assign u_v = ge2_q ? up_rd_q : 24'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win_q[r][c] <= 24'd0;
    end else if (cmd_i.step) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= ic0_q ? 24'd0 : win_q[r][1];
        win_q[r][1] <= ic0_q ? 24'd0 : win_q[r][2];
      end
      win_q[0][2] <= u_v;
      win_q[1][2] <= m_v;
      win_q[2][2] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      for (int r = 0; r < 3; r++) begin
        tmp_q[r][0] <= win_q[r][1];
        tmp_q[r][1] <= win_q[r][2];
      end
      if (ic0_q) begin
        for (int r = 0; r < 3; r++) tmp_q[r][2] <= 24'd0;
      end else begin
        tmp_q[0][2] <= u_v;
        tmp_q[1][2] <= m_v;
        tmp_q[2][2] <= pix_q;
      end
    end
  end

  // gradients and square sums, registered
  logic [16:0] sum_q [3];
  logic        sum_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sum_v_q <= 1'b0;
    else sum_v_q <= cmd_i.step;
  end

  always_ff @(posedge clk_i) begin
    if (sum_v_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic signed [11:0] gx, gy;
        logic [21:0] sx, sy;
        gx = $signed({4'd0, tmp_q[0][2][8*ch +: 8]}) - $signed({4'd0, tmp_q[0][0][8*ch +: 8]})
           + $signed({3'd0, tmp_q[1][2][8*ch +: 8], 1'b0})
           - $signed({3'd0, tmp_q[1][0][8*ch +: 8], 1'b0})
           + $signed({4'd0, tmp_q[2][2][8*ch +: 8]}) - $signed({4'd0, tmp_q[2][0][8*ch +: 8]});
        gy = $signed({4'd0, tmp_q[2][0][8*ch +: 8]}) - $signed({4'd0, tmp_q[0][0][8*ch +: 8]})
           + $signed({3'd0, tmp_q[2][1][8*ch +: 8], 1'b0})
           - $signed({3'd0, tmp_q[0][1][8*ch +: 8], 1'b0})
           + $signed({4'd0, tmp_q[2][2][8*ch +: 8]}) - $signed({4'd0, tmp_q[0][2][8*ch +: 8]});
        sx = 22'(gx * gx);
        sy = 22'(gy * gy);
        sum_q[ch] <= (sx + sy > 22'd65280) ? 17'h1FFFF : 17'(sx + sy);
      end
    end
  end

  // bit-serial square root, one result bit per step, MSB first
  logic [7:0] root_q [3];
  logic [2:0] bit_q;
  logic       sq_run_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q    <= 3'd7;
      sq_run_q <= 1'b0;
    end else if (sum_v_q) begin
      bit_q    <= 3'd7;
      sq_run_q <= 1'b1;
    end else if (cmd_i.sq_step && sq_run_q) begin
      if (bit_q == 3'd0) sq_run_q <= 1'b0;
      else bit_q <= bit_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_v_q) begin
      for (int ch = 0; ch < 3; ch++) root_q[ch] <= 8'd0;
    end else if (cmd_i.sq_step && sq_run_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic [7:0]  t;
        logic [15:0] tt;
        t = root_q[ch] | (8'd1 << bit_q);
        tt = 16'(t) * 16'(t);
        if ({1'b0, tt} <= sum_q[ch]) root_q[ch] <= t;
      end
    end
  end

  assign sts_o.sq_done = !sq_run_q && !sum_v_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (sum_q[ch] == 17'h1FFFF) mag_o[8*ch +: 8] = 8'd255;
      else if (sum_q[ch] > 17'({1'b0, 16'(16'(root_q[ch]) * 16'(root_q[ch]))})
                         + 17'(root_q[ch]))
        mag_o[8*ch +: 8] = root_q[ch] + 8'd1;
      else mag_o[8*ch +: 8] = root_q[ch];
    end
  end
endmodule

### hdl/sem_ctrl.sv
`timescale 1ns / 1ps
module sem_ctrl #(
  parameter int MaxWidth = sem_pkg::MaxWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_i,
  input  logic [10:0]       cfg_w_i,
  input  logic [12:0]       cfg_h_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              last_o,
  output logic              out_load_o,
  output sem_pkg::dp_cmd_t  cmd_o,
  input  sem_pkg::dp_sts_t  sts_i,
  output logic [$clog2(MaxWidth)-1:0] col_o,
  output logic              use_pix_o,
  output logic              row_ge1_o,
  output logic              row_ge2_o
);
  localparam int AW = $clog2(MaxWidth);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SStep = 3'd1;
  localparam logic [2:0] SSum  = 3'd2;
  localparam logic [2:0] SRoot = 3'd3;
  localparam logic [2:0] SOut  = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [12:0] col_q;
  logic [13:0] row_q;
  logic [24:0] cnt_q;
  logic [13:0] aw_q;
  logic [13:0] ah_q;
  logic        emit_q, last_q, ovalid_q;
  logic        start;
  logic [13:0] w_eff;
  logic [13:0] h_eff;

  assign start = (col_q == '0) && (row_q == '0) && (cnt_q == '0);
  assign w_eff = (cfg_w_i == '0) ? 14'd1 :
                 ({3'd0, cfg_w_i} > 14'(MaxWidth)) ? 14'(MaxWidth) : {3'd0, cfg_w_i};
  assign h_eff = (cfg_h_i == '0) ? 14'd1 :
                 ({1'b0, cfg_h_i} > 14'(sem_pkg::HeightLimit)) ? 14'(sem_pkg::HeightLimit)
                                                               : {1'b0, cfg_h_i};
  assign in_ready_o = (st_q == SIdle) && !ovalid_q;
  assign col_o = col_q[AW-1:0];
  assign row_ge1_o = row_q >= 14'd1;
  assign row_ge2_o = row_q >= 14'd2;
  assign use_pix_o = (row_q < ah_q) && !req_i;
  assign out_valid_o = ovalid_q;
  assign last_o = last_q;

  logic acc;
  assign acc = in_valid_i && in_ready_o && !(start && req_i);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = acc;
    cmd_o.step = (st_q == SStep);
    cmd_o.sq_step = (st_q == SRoot);
    st_d = st_q;
    out_load_o = 1'b0;
    case (st_q)
      SIdle: if (acc) st_d = SStep;
      SStep: st_d = emit_q ? SSum : SIdle;
      SSum:  st_d = SRoot;
      SRoot: if (sts_i.sq_done) st_d = SOut;
      SOut: begin
        out_load_o = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
      aw_q <= 14'(MaxWidth);
      ah_q <= 14'd768;
      emit_q <= 1'b0;
      last_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      if (out_load_o) ovalid_q <= 1'b1;
      if (acc) begin
        logic [13:0] w;
        w = start ? w_eff : aw_q;
        if (start) begin
          aw_q <= w_eff;
          ah_q <= h_eff;
        end
        emit_q <= (row_q >= 14'd2) || (row_q == 14'd1 && col_q != '0);
        if ({1'b0, col_q} + 14'd1 >= w) begin
          col_q <= '0;
          row_q <= row_q + 14'd1;
        end else col_q <= col_q + 13'd1;
      end
      if (st_q == SStep && emit_q) begin
        if (25'(cnt_q) + 25'd1 >= 25'(aw_q) * 25'(ah_q)) begin
          last_q <= 1'b1;
          cnt_q <= '0;
          col_q <= '0;
          row_q <= '0;
        end else begin
          last_q <= 1'b0;
          cnt_q <= cnt_q + 25'd1;
        end
      end
    end
  end
endmodule

### hdl/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
// channel   dir  payload
// in_ch     in   req_type, pixel_red/green/blue
// out_ch    out  edge_red/green/blue, frame_last
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// A beat with a result passes through line-buffer read, window step,
// gradient sums, the bit-serial square root and the output load; a beat
// with no result passes only the line-buffer read and window step.
// Reset clears control and window; line buffers hold garbage until written.
// The output register holds a result until taken; input stalls meanwhile.
module sobel_edge_magnitude_rgb #(
  parameter int MaxWidth = sem_pkg::MaxWidthDefault
) (
  input logic clk_i,
  input logic rst_ni,
  sem_if.sink   in_ch,
  sem_if.source out_ch,
  input logic                         cfg_we_i,
  input logic [sem_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [sem_pkg::CfgDataW-1:0] cfg_data_i
);
  logic [10:0] fw_q;
  logic [12:0] fh_q;
  sem_pkg::dp_cmd_t cmd;
  sem_pkg::dp_sts_t sts;
  logic [$clog2(MaxWidth)-1:0] col;
  logic use_pix, ge1, ge2, ld, last;
  logic [23:0] mag;
  sem_pkg::out_beat_t ob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 11'd1024;
      fh_q <= 13'd768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sem_pkg::RegFrameWidth:  fw_q <= cfg_data_i[10:0];
        sem_pkg::RegFrameHeight: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sem_ctrl #(.MaxWidth(MaxWidth)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .req_i(in_ch.data.req_type),
    .cfg_w_i(fw_q), .cfg_h_i(fh_q),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .last_o(last),
    .out_load_o(ld), .cmd_o(cmd), .sts_i(sts), .col_o(col),
    .use_pix_o(use_pix), .row_ge1_o(ge1), .row_ge2_o(ge2)
  );

  sem_datapath #(.MaxWidth(MaxWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .pix_i({in_ch.data.pixel_blue, in_ch.data.pixel_green, in_ch.data.pixel_red}),
    .col_i(col), .use_pix_i(use_pix), .row_ge1_i(ge1), .row_ge2_i(ge2), .mag_o(mag)
  );

  always_ff @(posedge clk_i) begin
    if (ld) begin
      ob_q.edge_red   <= mag[7:0];
      ob_q.edge_green <= mag[15:8];
      ob_q.edge_blue  <= mag[23:16];
      ob_q.frame_last <= last;
    end
  end
  assign out_ch.data = ob_q;
endmodule

### hdl/sem_checker.sv
`timescale 1ns / 1ps
module sem_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [7:0] edge_red_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("out dropped");
  a_red_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(edge_red_i)) else $error("out changed");
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("ready with pending result");
  a_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i) else $error("result repeated");
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_chk (
  .clk_i, .rst_ni,
  .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
  .edge_red_i(out_ch.data.edge_red)
);
